// ===== hdl/mpfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfc_pkg: shared types and constants for the memory pattern fill/check block
// Transaction payloads, pattern mode and operation codes, register indexes,
// and the pseudo-random sequence constants.
// ----------------------------------------------------------------------------
package mpfc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned RandW = 31;

  // LCG: next = (prev * mul + add) mod 2^31
  localparam logic [RandW-1:0] LcgMul = 31'd1103515245;
  localparam logic [RandW-1:0] LcgAdd = 31'd12345;

  typedef enum logic [1:0] {
    MODE_CONST  = 2'd0,
    MODE_ADDR   = 2'd1,
    MODE_RANDOM = 2'd2
  } mode_t;

  typedef enum logic {
    OP_FILL  = 1'b0,
    OP_CHECK = 1'b1
  } op_t;

  typedef enum logic {
    REG_PATTERN_MODE = 1'b0,
    REG_FILL_VALUE   = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic             operation;
    logic [DataW-1:0] word_address;
    logic [DataW-1:0] read_data;
    logic             first_word;
    logic             last_word;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0] pattern_word;
    logic             mismatch;
    logic             error_seen;
    logic [DataW-1:0] first_error_address;
    logic             run_done;
  } out_item_t;

  // per-word control shared by the pattern and capture units
  typedef struct packed {
    logic fire;        // word moves from input register to result register
    logic first_word;  // word opens a new run
  } step_ctl_t;

endpackage

// ===== hdl/mpfc_pattern_gen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfc_pattern_gen: pattern word generator
// Selects constant, address or pseudo-random data and holds the 31-bit
// sequence state, which advances only on words processed in random mode.
// ----------------------------------------------------------------------------
module mpfc_pattern_gen import mpfc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  step_ctl_t        ctl,
  input  logic [1:0]       pattern_mode,
  input  logic [DataW-1:0] fill_value,
  input  logic [DataW-1:0] word_address,
  output logic [DataW-1:0] pattern_word
);

  logic [RandW-1:0] random_value;
  logic [RandW-1:0] rand_base;
  logic [RandW-1:0] random_value_next;

  assign rand_base         = ctl.first_word ? '0 : random_value;
  // only the low 31 bits of the product matter
  assign random_value_next = RandW'(rand_base * LcgMul + LcgAdd);

  always_comb begin
    case (pattern_mode)
      MODE_ADDR:   pattern_word = word_address;
      MODE_RANDOM: pattern_word = {{(DataW-RandW){1'b0}}, random_value_next};
      default:     pattern_word = fill_value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      random_value <= '0;
    end else if (ctl.fire) begin
      if (pattern_mode == MODE_RANDOM) begin
        random_value <= random_value_next;
      end else if (ctl.first_word) begin
        random_value <= '0;
      end
    end
  end

endmodule

// ===== hdl/mpfc_error_capture.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfc_error_capture: read data compare and first-error capture
// Flags a mismatch on check words and keeps a sticky error flag plus the
// address of the first failing word of the run.
// ----------------------------------------------------------------------------
module mpfc_error_capture import mpfc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  step_ctl_t        ctl,
  input  logic             operation,
  input  logic [DataW-1:0] word_address,
  input  logic [DataW-1:0] read_data,
  input  logic [DataW-1:0] pattern_word,
  output logic             mismatch,
  output logic             error_seen,
  output logic [DataW-1:0] first_error_address
);

  logic             error_flag;
  logic [DataW-1:0] error_address;
  logic             flag_base;
  logic [DataW-1:0] addr_base;
  logic             error_flag_next;
  logic [DataW-1:0] error_address_next;

  assign flag_base = ctl.first_word ? 1'b0 : error_flag;
  assign addr_base = ctl.first_word ? '0 : error_address;

  assign mismatch           = (operation == OP_CHECK) && (read_data != pattern_word);
  assign error_flag_next    = flag_base | mismatch;
  assign error_address_next = (!flag_base && mismatch) ? word_address : addr_base;

  assign error_seen          = error_flag_next;
  assign first_error_address = error_flag_next ? error_address_next : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      error_flag    <= 1'b0;
      error_address <= '0;
    end else if (ctl.fire) begin
      error_flag    <= error_flag_next;
      error_address <= error_address_next;
    end
  end

endmodule

// ===== hdl/memory_pattern_fill_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_pattern_fill_check: memory test pattern generator and checker
// Produces fill data or checks read-back data for 32-bit memory words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one word per
//   transaction: operation, byte address, read-back data and run markers.
//   Output channel (out_valid/out_ready/out_data) returns one result per
//   word: pattern word, mismatch, sticky error flag, first error address
//   and run_done on the last word.
//   Configuration: cfg_write_en/cfg_index/cfg_write_data, written while idle.
//   Results are registered: the accepting edge loads the input register and
//   the word moves on to the result register when the output is not stalled.
//   Throughput: one word per cycle unless out_ready stalls the result; the LCG
//   multiply-add feeding its state register sets the cycle time.
//   Reset: clears both pipeline valids, the mode (constant), the fill value,
//   the random sequence state and the error capture.
//   Stall: while out_ready is low with a result held, the input register
//   holds its word and in_ready drops once it is occupied.
// ----------------------------------------------------------------------------
module memory_pattern_fill_check import mpfc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_write_en,
  input  logic             cfg_index,
  input  logic [DataW-1:0] cfg_write_data
);

  logic [1:0]       pattern_mode;
  logic [DataW-1:0] fill_value;

  logic             stage_valid;
  in_item_t         stage_item;
  logic             stage_advance;
  step_ctl_t        ctl;
  out_item_t        result;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_mode <= MODE_CONST;
      fill_value   <= '0;
    end else if (cfg_write_en) begin
      case (reg_index_t'(cfg_index))
        REG_PATTERN_MODE: pattern_mode <= cfg_write_data[1:0];
        REG_FILL_VALUE:   fill_value   <= cfg_write_data;
        default:          ;
      endcase
    end
  end

  assign stage_advance = stage_valid && (!out_valid || out_ready);
  assign in_ready      = !stage_valid || stage_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_data;
    end
  end

  assign ctl.fire       = stage_advance;
  assign ctl.first_word = stage_item.first_word;

  mpfc_pattern_gen u_pattern_gen (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .pattern_mode (pattern_mode),
    .fill_value   (fill_value),
    .word_address (stage_item.word_address),
    .pattern_word (result.pattern_word)
  );

  mpfc_error_capture u_error_capture (
    .clk                 (clk),
    .rst                 (rst),
    .ctl                 (ctl),
    .operation           (stage_item.operation),
    .word_address        (stage_item.word_address),
    .read_data           (stage_item.read_data),
    .pattern_word        (result.pattern_word),
    .mismatch            (result.mismatch),
    .error_seen          (result.error_seen),
    .first_error_address (result.first_error_address)
  );

  assign result.run_done = stage_item.last_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_advance) begin
      out_data <= result;
    end
  end

  // a word waiting behind a stalled result must not be dropped
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !stage_advance |=> stage_valid)
    else $error("input register lost a word while stalled");

  a_miss_sets_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.mismatch |-> out_data.error_seen)
    else $error("mismatch without sticky error flag");

  a_no_error_addr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.error_seen |-> out_data.first_error_address == '0)
    else $error("error address nonzero with no error seen");

  a_fill_no_miss: assert property (@(posedge clk) disable iff (rst)
    stage_advance && stage_item.operation == OP_FILL |=> !out_data.mismatch)
    else $error("mismatch flagged on a fill word");

  a_random_width: assert property (@(posedge clk) disable iff (rst)
    stage_advance && pattern_mode == MODE_RANDOM |=> !out_data.pattern_word[DataW-1])
    else $error("random pattern exceeds 31 bits");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for memory_pattern_fill_check
// A queue-fed driver sends memory word transactions with random gaps while
// the result side stalls at random. Every accepted word runs through a
// cycle-level pattern/capture predictor; results are compared field by
// field in order. Directed runs cover pattern modes, the unused mode code,
// runs that span mode changes and error capture; random runs follow.
// ----------------------------------------------------------------------------
module tb;
  import mpfc_pkg::*;

  localparam int CycleLimit = 400000;
  localparam logic [1:0] ModeUnused = 2'd3;  // decodes as constant fill

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_write_en = 1'b0;
  logic             cfg_index = 1'b0;
  logic [DataW-1:0] cfg_write_data = '0;

  memory_pattern_fill_check dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_write_data (cfg_write_data)
  );

  always #4 clk = ~clk;

  in_item_t  pending_words[$];
  out_item_t results_due[$];

  int   fail_count = 0;
  int   cycle_count = 0;
  int   send_gap = 0;
  int   recv_stall = 0;
  bit   drain_hold = 1'b0;
  bit   quiet_in = 1'b0;
  bit   quiet_out = 1'b0;
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;

  // shadow configuration and run state
  logic [1:0]       cfg_mode = MODE_CONST;
  logic [DataW-1:0] cfg_fill = '0;
  logic [RandW-1:0] lcg_state = '0;
  logic             err_flag = 1'b0;
  logic [DataW-1:0] err_addr = '0;
  // sequence tracked while building stimulus, so check data can match
  logic [RandW-1:0] stim_lcg = '0;

  function automatic logic [RandW-1:0] lcg_next(logic [RandW-1:0] v);
    return v * LcgMul + LcgAdd;
  endfunction

  function automatic out_item_t predict_result(in_item_t w);
    out_item_t        r;
    logic [DataW-1:0] pat;
    if (w.first_word) begin
      lcg_state = '0;
      err_flag  = 1'b0;
      err_addr  = '0;
    end
    if (cfg_mode == MODE_ADDR) begin
      pat = w.word_address;
    end else if (cfg_mode == MODE_RANDOM) begin
      lcg_state = lcg_next(lcg_state);
      pat = {1'b0, lcg_state};
    end else begin
      pat = cfg_fill;
    end
    r.pattern_word = pat;
    r.mismatch = (w.operation == OP_CHECK) && (w.read_data != pat);
    if (r.mismatch && !err_flag) begin
      err_flag = 1'b1;
      err_addr = w.word_address;
    end
    r.error_seen = err_flag;
    r.first_error_address = err_flag ? err_addr : '0;
    r.run_done = w.last_word;
    return r;
  endfunction

  function automatic logic [DataW-1:0] stim_pattern(logic first, logic [DataW-1:0] addr);
    logic [DataW-1:0] pat;
    if (first) stim_lcg = '0;
    if (cfg_mode == MODE_ADDR) begin
      pat = addr;
    end else if (cfg_mode == MODE_RANDOM) begin
      stim_lcg = lcg_next(stim_lcg);
      pat = {1'b0, stim_lcg};
    end else begin
      pat = cfg_fill;
    end
    return pat;
  endfunction

  // read data is the pattern xor flip, so flip = 0 reads back clean
  task automatic add_word(op_t op, logic [DataW-1:0] addr, logic first, logic last,
                          logic [DataW-1:0] flip);
    in_item_t w;
    w.operation    = op;
    w.word_address = addr;
    w.first_word   = first;
    w.last_word    = last;
    w.read_data    = stim_pattern(first, addr) ^ flip;
    pending_words.push_back(w);
  endtask

  task automatic add_run(int len, bit closed);
    int               i;
    op_t              op;
    logic [DataW-1:0] base;
    logic [DataW-1:0] flip;
    base = $urandom;
    if ($urandom_range(0, 3) != 0) base[1:0] = 2'b00;
    for (i = 0; i < len; i++) begin
      op = ($urandom_range(0, 9) < 7) ? OP_CHECK : OP_FILL;
      flip = '0;
      if ($urandom_range(0, 11) == 0) flip = 32'd1 << $urandom_range(0, 31);
      else if ($urandom_range(0, 30) == 0) flip = $urandom;
      if (op == OP_FILL && $urandom_range(0, 1) == 1) flip = $urandom;
      add_word(op, base + 4 * i, i == 0, closed && (i == len - 1), flip);
    end
  endtask

  task automatic write_reg(reg_index_t idx, logic [DataW-1:0] val);
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_index      <= idx;
    cfg_write_data <= val;
    if (idx == REG_PATTERN_MODE) cfg_mode = val[1:0];
    else cfg_fill = val;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // sampled at posedge, where the driver's negedge updates have settled
  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic check_field(string name, logic [DataW-1:0] want, logic [DataW-1:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 200) $error("%s: expected %h, got %h", name, want, got);
    end
  endtask

  // input driver
  always @(negedge clk) begin : send
    logic     nxt_valid;
    in_item_t nxt_data;
    nxt_valid = in_valid;
    nxt_data  = in_data;
    if (in_valid && in_taken) nxt_valid = 1'b0;
    if (!nxt_valid && !rst) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (drain_hold) begin
        if (results_due.size() == 0) drain_hold = 1'b0;
      end else if (pending_words.size() > 0) begin
        nxt_data   = pending_words.pop_front();
        nxt_valid  = 1'b1;
        send_gap   = quiet_in ? 0 : $urandom_range(0, 9);
        drain_hold = ($urandom_range(0, 63) == 0);
      end
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_data;
  end

  // result side backpressure
  always @(negedge clk) begin : accept
    if (out_taken && !quiet_out) recv_stall = $urandom_range(0, 9);
    if (recv_stall > 0) begin
      out_ready <= 1'b0;
      recv_stall--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin : watch
    out_item_t want;
    logic      in_fire;
    logic      out_fire;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      in_fire  = !rst && in_valid && in_ready;
      out_fire = !rst && out_valid && out_ready;
      if (out_fire) begin
        if (results_due.size() == 0) begin
          fail_count++;
          $error("unexpected result transaction: %p", out_data);
        end else begin
          want = results_due.pop_front();
          check_field("pattern_word", want.pattern_word, out_data.pattern_word);
          check_field("mismatch", DataW'(want.mismatch), DataW'(out_data.mismatch));
          check_field("error_seen", DataW'(want.error_seen), DataW'(out_data.error_seen));
          check_field("first_error_address", want.first_error_address,
                      out_data.first_error_address);
          check_field("run_done", DataW'(want.run_done), DataW'(out_data.run_done));
        end
      end
      if (in_fire) results_due.push_back(predict_result(in_data));
      in_taken  <= in_fire;
      out_taken <= out_fire;
    end
  end

  initial begin : stimulus
    int         p;
    int         n;
    int         len;
    logic [1:0] mode_pick;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // constant mode, all-ones fill; error capture and carry-over after last
    write_reg(REG_PATTERN_MODE, DataW'(MODE_CONST));
    write_reg(REG_FILL_VALUE, 32'hFFFF_FFFF);
    add_word(OP_FILL, 32'h0000_0000, 1'b1, 1'b0, 32'h1234_5678);
    add_word(OP_CHECK, 32'hFFFF_FFFC, 1'b0, 1'b0, 32'h0000_0000);
    add_word(OP_CHECK, 32'h0000_0004, 1'b0, 1'b0, 32'hFFFF_FFFF);
    add_word(OP_CHECK, 32'h0000_0008, 1'b0, 1'b0, 32'h8000_0000);
    add_word(OP_FILL, 32'h0000_000C, 1'b0, 1'b1, 32'h0000_0000);
    add_word(OP_CHECK, 32'h0000_0010, 1'b0, 1'b0, 32'h0000_0000);
    wait_idle();

    write_reg(REG_PATTERN_MODE, DataW'(MODE_ADDR));
    add_word(OP_CHECK, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000);
    add_word(OP_CHECK, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000);
    add_word(OP_CHECK, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'hFFFF_FFFF);
    add_word(OP_FILL, 32'h5555_5555, 1'b0, 1'b1, 32'h0000_0000);
    wait_idle();

    // random run left open across mode changes
    write_reg(REG_PATTERN_MODE, DataW'(MODE_RANDOM));
    add_word(OP_FILL, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000);
    add_word(OP_CHECK, 32'h0000_0004, 1'b0, 1'b0, 32'h0000_0000);
    add_word(OP_CHECK, 32'h0000_0008, 1'b0, 1'b0, 32'h0000_0001);
    wait_idle();
    write_reg(REG_PATTERN_MODE, DataW'(MODE_ADDR));
    add_word(OP_CHECK, 32'h0000_0100, 1'b0, 1'b0, 32'h0000_0000);
    add_word(OP_FILL, 32'h0000_0104, 1'b0, 1'b0, 32'h0000_0000);
    wait_idle();
    write_reg(REG_PATTERN_MODE, DataW'(MODE_RANDOM));
    add_word(OP_CHECK, 32'h0000_000C, 1'b0, 1'b0, 32'h0000_0000);
    add_word(OP_CHECK, 32'h0000_0010, 1'b0, 1'b1, 32'h0000_0000);
    wait_idle();

    write_reg(REG_PATTERN_MODE, DataW'(ModeUnused));
    write_reg(REG_FILL_VALUE, 32'h0000_0000);
    add_word(OP_CHECK, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000);
    add_word(OP_CHECK, 32'h0000_0004, 1'b0, 1'b0, 32'h0000_0001);
    add_word(OP_CHECK, 32'h0000_0008, 1'b0, 1'b1, 32'h0000_0000);
    wait_idle();

    for (p = 0; p < 12; p++) begin
      mode_pick = (p < 4) ? 2'(p) : 2'($urandom_range(0, 3));
      write_reg(REG_PATTERN_MODE, {30'd0, mode_pick});
      case ($urandom_range(0, 3))
        0:       write_reg(REG_FILL_VALUE, 32'h0000_0000);
        1:       write_reg(REG_FILL_VALUE, 32'hFFFF_FFFF);
        default: write_reg(REG_FILL_VALUE, $urandom);
      endcase
      quiet_in  = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      n = 0;
      while (n < 115) begin
        if ($urandom_range(0, 99) < 85) begin
          len = $urandom_range(1, 24);
          add_run(len, $urandom_range(0, 9) != 0);
          n += len;
        end else begin
          // stray transaction: random markers and read data
          add_word(op_t'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), $urandom);
          n++;
        end
      end
      wait_idle();
    end

    repeat (8) @(negedge clk);
    if (fail_count == 0 && results_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
